>>> rtl/xor_clause_text_parser_assert.svh
// Assertion macros shared by the checker of the XOR clause text parser.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef XOR_CLAUSE_TEXT_PARSER_ASSERT_SVH
`define XOR_CLAUSE_TEXT_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/xcp_pkg.sv
// Types and character constants for the XOR clause text parser.
// No dependencies; used by the interfaces, the step logic, top level and checker.
`timescale 1ns / 1ps

package xcp_pkg;

  localparam int FIELD_BITS = 24;

  typedef enum logic [6:0] {
    MODE_BETWEEN = 7'b0000001,
    MODE_COMMENT = 7'b0000010,
    MODE_CLAUSE  = 7'b0000100,
    MODE_NUMBER  = 7'b0001000,
    MODE_PLUS    = 7'b0010000,
    MODE_CONST   = 7'b0100000,
    MODE_ERROR   = 7'b1000000
  } mode_t;

  typedef enum logic [1:0] {
    KIND_VAR  = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_UPPER_T = 8'h54;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_P = 8'h70;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef struct packed {
    kind_t                 kind;
    logic [FIELD_BITS-1:0] var_index;
    logic                  odd_true;
    logic [FIELD_BITS-1:0] max_var;
    logic                  last;
  } res_t;

  // Results caused by one text byte: up to two, in order.
  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } step_res_t;

endpackage

>>> rtl/xcp_if.sv
// Valid/ready channel interfaces for the XOR clause text parser.
// Depends on xcp_pkg for the field width.
`timescale 1ns / 1ps

interface xcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface xcp_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [xcp_pkg::FIELD_BITS-1:0] var_index;
  logic                           odd_true;
  logic [xcp_pkg::FIELD_BITS-1:0] max_var;
  logic                           last;

  modport source (output valid, output kind, output var_index, output odd_true,
                  output max_var, output last, input ready);
  modport sink   (input valid, input kind, input var_index, input odd_true,
                  input max_var, input last, output ready);
endinterface

>>> rtl/xor_clause_text_parser.sv
// XOR clause text parser, top level.
// Channels: in_ch takes one text byte per request (valid/ready), out_ch gives
// result requests: kind, var_index, odd_true, max_var and a last flag that
// marks the final result caused by a byte. A byte yields zero, one or two
// results.
// A byte is parsed in the cycle it is accepted; its results are registered
// into the result queue and reach out_ch from the next cycle if it was empty.
// Throughput: one byte per cycle while each byte yields at most one result
// and the receiver keeps up. A byte yielding two results holds off input
// while the single output port drains the three-entry result queue.
// in_ch.ready decodes the queue count register: high while the queue holds at
// most one result.
// When the receiver stalls, the head result holds and the queue fills; input
// then stops after at most two more results are queued.
// Reset clears the parser state (between clauses, counters zero) and empties
// the result queue. A parse error is sticky until reset; a 0 byte outside a
// clause ends the text and restarts with fresh state.
// Depends on xcp_pkg, xcp_if and xcp_step.
`timescale 1ns / 1ps

module xor_clause_text_parser #(
  parameter int INDEX_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  xcp_in_if.sink           in_ch,
  xcp_out_if.source        out_ch
);

  localparam int QDEPTH = 3;

  xcp_pkg::mode_t        mode_r;
  xcp_pkg::mode_t        mode_nxt;
  logic [INDEX_BITS-1:0] accum_r;
  logic [INDEX_BITS-1:0] accum_nxt;
  logic                  parity_r;
  logic                  parity_nxt;
  logic [INDEX_BITS-1:0] largest_r;
  logic [INDEX_BITS-1:0] largest_nxt;
  xcp_pkg::step_res_t    step_res;

  xcp_pkg::res_t         q_r   [QDEPTH];
  xcp_pkg::res_t         q_nxt [QDEPTH];
  logic [1:0]            cnt_r;
  logic [1:0]            cnt_nxt;
  logic [1:0]            base;
  logic                  push;
  logic                  pop;

  xcp_step #(
    .INDEX_BITS (INDEX_BITS)
  ) u_step (
    .text_byte   (in_ch.text_byte),
    .mode        (mode_r),
    .accum       (accum_r),
    .parity      (parity_r),
    .largest     (largest_r),
    .mode_nxt    (mode_nxt),
    .accum_nxt   (accum_nxt),
    .parity_nxt  (parity_nxt),
    .largest_nxt (largest_nxt),
    .step_res    (step_res)
  );

  assign in_ch.ready = (cnt_r <= 2'd1);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= xcp_pkg::MODE_BETWEEN;
      accum_r   <= '0;
      parity_r  <= 1'b0;
      largest_r <= '0;
    end else if (push) begin
      mode_r    <= mode_nxt;
      accum_r   <= accum_nxt;
      parity_r  <= parity_nxt;
      largest_r <= largest_nxt;
    end
  end

  // Result queue: entry 0 is the head; pop shifts down, push appends.
  always_comb begin
    q_nxt = q_r;
    base  = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      base     = cnt_r - 2'd1;
    end
    if (push) begin
      if (step_res.n != 2'd0) begin
        q_nxt[base] = step_res.r0;
      end
      if (step_res.n == 2'd2) begin
        q_nxt[base + 2'd1] = step_res.r1;
      end
      cnt_nxt = base + step_res.n;
    end else begin
      cnt_nxt = base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.kind      = q_r[0].kind;
  assign out_ch.var_index = q_r[0].var_index;
  assign out_ch.odd_true  = q_r[0].odd_true;
  assign out_ch.max_var   = q_r[0].max_var;
  assign out_ch.last      = q_r[0].last;

endmodule

>>> rtl/xcp_step.sv
// Per-byte parse logic: next parser state and the results caused by one byte.
// Purely combinational; depends on xcp_pkg.
`timescale 1ns / 1ps

module xcp_step #(
  parameter int INDEX_BITS = 24
) (
  input  logic [7:0]            text_byte,
  input  xcp_pkg::mode_t        mode,
  input  logic [INDEX_BITS-1:0] accum,
  input  logic                  parity,
  input  logic [INDEX_BITS-1:0] largest,
  output xcp_pkg::mode_t        mode_nxt,
  output logic [INDEX_BITS-1:0] accum_nxt,
  output logic                  parity_nxt,
  output logic [INDEX_BITS-1:0] largest_nxt,
  output xcp_pkg::step_res_t    step_res
);

  localparam int FB = xcp_pkg::FIELD_BITS;
  localparam int WB = INDEX_BITS + 4;

  logic                  is_space;
  logic                  is_digit;
  logic [3:0]            digit;
  logic [INDEX_BITS-1:0] digit_ext;
  logic [WB-1:0]         times_ten;
  logic                  overflow;
  logic                  do_between;
  logic                  do_token;
  logic                  do_fail;
  logic [1:0]            cnt;
  xcp_pkg::res_t         res [2];

  function automatic xcp_pkg::res_t mk_res(input xcp_pkg::kind_t k,
                                           input logic [INDEX_BITS-1:0] v,
                                           input logic o,
                                           input logic [INDEX_BITS-1:0] m);
    xcp_pkg::res_t r;
    r.kind      = k;
    r.var_index = FB'(v);
    r.odd_true  = o;
    r.max_var   = FB'(m);
    r.last      = 1'b0;
    return r;
  endfunction

  assign is_space  = ((text_byte >= xcp_pkg::CH_TAB) && (text_byte <= xcp_pkg::CH_CR)) ||
                     (text_byte == xcp_pkg::CH_SPACE);
  assign is_digit  = (text_byte >= xcp_pkg::CH_ZERO) && (text_byte <= xcp_pkg::CH_NINE);
  assign digit     = text_byte[3:0];
  assign digit_ext = INDEX_BITS'(digit);
  // accum * 10 + digit as two shifts and adds; overflow when any top bit is set
  assign times_ten = (WB'(accum) << 3) + (WB'(accum) << 1) + WB'(digit);
  assign overflow  = |times_ten[WB-1:INDEX_BITS];

  always_comb begin
    mode_nxt    = mode;
    accum_nxt   = accum;
    parity_nxt  = parity;
    largest_nxt = largest;
    do_between  = 1'b0;
    do_token    = 1'b0;
    do_fail     = 1'b0;
    cnt         = 2'd0;
    res[0]      = '0;
    res[1]      = '0;

    unique case (mode)
      xcp_pkg::MODE_BETWEEN: do_between = 1'b1;
      xcp_pkg::MODE_COMMENT: begin
        if (text_byte == xcp_pkg::CH_NEWLINE) begin
          mode_nxt = xcp_pkg::MODE_BETWEEN;
        end else if (text_byte == xcp_pkg::CH_NUL) begin
          do_between = 1'b1;
        end
      end
      xcp_pkg::MODE_CLAUSE: do_token = 1'b1;
      xcp_pkg::MODE_PLUS: begin
        if (is_digit) begin
          accum_nxt = digit_ext;
          mode_nxt  = xcp_pkg::MODE_NUMBER;
        end else begin
          do_fail = 1'b1;
        end
      end
      xcp_pkg::MODE_CONST: begin
        if (is_space) begin
          mode_nxt = xcp_pkg::MODE_CLAUSE;
        end else begin
          do_fail = 1'b1;
        end
      end
      xcp_pkg::MODE_NUMBER: begin
        if (is_digit) begin
          if (overflow) begin
            do_fail = 1'b1;
          end else begin
            accum_nxt = times_ten[INDEX_BITS-1:0];
          end
        end else if (accum == '0) begin
          // number zero closes the clause
          res[0]     = mk_res(xcp_pkg::KIND_END, '0, parity, largest_nxt);
          cnt        = 2'd1;
          parity_nxt = 1'b0;
          mode_nxt   = xcp_pkg::MODE_BETWEEN;
          do_between = 1'b1;
        end else begin
          if (accum > largest_nxt) begin
            largest_nxt = accum;
          end
          res[0]    = mk_res(xcp_pkg::KIND_VAR, accum, 1'b0, largest_nxt);
          cnt       = 2'd1;
          accum_nxt = '0;
          mode_nxt  = xcp_pkg::MODE_CLAUSE;
          do_token  = 1'b1;
        end
      end
      default: do_fail = 1'b1;
    endcase

    if (do_between) begin
      if (is_space) begin
        // skip
      end else if (text_byte == xcp_pkg::CH_NUL) begin
        res[cnt[0]] = mk_res(xcp_pkg::KIND_DONE, '0, 1'b0, largest_nxt);
        cnt         = cnt + 2'd1;
        mode_nxt    = xcp_pkg::MODE_BETWEEN;
        accum_nxt   = '0;
        parity_nxt  = 1'b0;
        largest_nxt = '0;
      end else if ((text_byte == xcp_pkg::CH_LOWER_C) ||
                   (text_byte == xcp_pkg::CH_LOWER_P)) begin
        mode_nxt = xcp_pkg::MODE_COMMENT;
      end else begin
        parity_nxt = 1'b0;
        do_token   = 1'b1;
      end
    end

    if (do_token) begin
      if (is_space) begin
        mode_nxt = xcp_pkg::MODE_CLAUSE;
      end else if ((text_byte == xcp_pkg::CH_LOWER_T) ||
                   (text_byte == xcp_pkg::CH_UPPER_T)) begin
        parity_nxt = ~parity_nxt;
        mode_nxt   = xcp_pkg::MODE_CONST;
      end else if ((text_byte == xcp_pkg::CH_LOWER_F) ||
                   (text_byte == xcp_pkg::CH_UPPER_F)) begin
        mode_nxt = xcp_pkg::MODE_CONST;
      end else if (text_byte == xcp_pkg::CH_PLUS) begin
        mode_nxt = xcp_pkg::MODE_PLUS;
      end else if (is_digit) begin
        accum_nxt = digit_ext;
        mode_nxt  = xcp_pkg::MODE_NUMBER;
      end else begin
        do_fail = 1'b1;
      end
    end

    if (do_fail) begin
      res[cnt[0]] = mk_res(xcp_pkg::KIND_ERR, '0, 1'b0, largest_nxt);
      cnt         = cnt + 2'd1;
      mode_nxt    = xcp_pkg::MODE_ERROR;
    end

    // flag the final result of this byte
    if (cnt == 2'd2) begin
      res[1].last = 1'b1;
    end else if (cnt == 2'd1) begin
      res[0].last = 1'b1;
    end

    step_res.r0 = res[0];
    step_res.r1 = res[1];
    step_res.n  = cnt;
  end

endmodule

>>> rtl/xcp_checker.sv
// Port-level checker for the XOR clause text parser, bound to the top level.
// Depends on xcp_pkg and xor_clause_text_parser_assert.svh.
`timescale 1ns / 1ps
`include "xor_clause_text_parser_assert.svh"

module xcp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     kind,
  input logic [xcp_pkg::FIELD_BITS-1:0] var_index,
  input logic                           odd_true,
  input logic [xcp_pkg::FIELD_BITS-1:0] max_var,
  input logic                           last
);

  `XCP_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(var_index) && $stable(odd_true) && $stable(max_var) && $stable(last), "result changed while stalled")
  `XCP_ASSERT_NOW(a_var_bounded, out_valid && (kind == xcp_pkg::KIND_VAR), (var_index != '0) && (max_var >= var_index) && !odd_true, "variable result out of range")
  `XCP_ASSERT_NOW(a_other_zero, out_valid && (kind != xcp_pkg::KIND_VAR), (var_index == '0) && ((kind == xcp_pkg::KIND_END) || !odd_true), "stray fields on non-variable result")
  `XCP_ASSERT_NEXT(a_err_sticky, out_valid && out_ready && (kind == xcp_pkg::KIND_ERR), !out_valid || (kind == xcp_pkg::KIND_ERR), "result after error is not an error")
  // Done and error always close the results of their byte.
  `XCP_ASSERT_NOW(a_final_last, out_valid && ((kind == xcp_pkg::KIND_DONE) || (kind == xcp_pkg::KIND_ERR)), last, "done or error result not flagged last")

endmodule

bind xor_clause_text_parser xcp_checker u_xcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .kind      (out_ch.kind),
  .var_index (out_ch.var_index),
  .odd_true  (out_ch.odd_true),
  .max_var   (out_ch.max_var),
  .last      (out_ch.last)
);

>>> bench/xor_clause_text_parser_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the XOR clause text parser: follows every accepted text byte,
// predicts the result requests it causes and compares them in order.
// Depends on xcp_pkg and the channel interfaces in xcp_if.

module xor_clause_text_parser_checker (
  input  logic clk,
  input  logic rst_n,
  xcp_in_if    in_ch,
  xcp_out_if   out_ch,
  output int   fail_count,
  output int   pending_count,
  output int   results_seen,
  output int   clauses_seen,
  output int   texts_seen
);

  localparam int FB = xcp_pkg::FIELD_BITS;
  localparam logic [31:0] INDEX_MAX = (32'd1 << FB) - 32'd1;

  xcp_pkg::mode_t  parse_state;
  logic [FB-1:0]   digits_val;
  logic            clause_odd;
  logic [FB-1:0]   max_index;
  xcp_pkg::res_t   byte_results[$];
  xcp_pkg::res_t   expected_results[$];

  function automatic bit is_blank(logic [7:0] ch);
    return (ch >= xcp_pkg::CH_TAB && ch <= xcp_pkg::CH_CR) || ch == xcp_pkg::CH_SPACE;
  endfunction

  function automatic bit is_digit(logic [7:0] ch);
    return ch >= xcp_pkg::CH_ZERO && ch <= xcp_pkg::CH_NINE;
  endfunction

  function automatic string show(xcp_pkg::res_t r);
    return $sformatf("kind %0d var %0d odd %0b max %0d last %0b",
                     r.kind, r.var_index, r.odd_true, r.max_var, r.last);
  endfunction

  function automatic void note(xcp_pkg::kind_t k, logic [FB-1:0] v, logic odd);
    xcp_pkg::res_t r;
    r.kind      = k;
    r.var_index = v;
    r.odd_true  = odd;
    r.max_var   = max_index;
    r.last      = 1'b0;
    byte_results.push_back(r);
  endfunction

  function automatic void clear_text();
    parse_state = xcp_pkg::MODE_BETWEEN;
    digits_val  = '0;
    clause_odd  = 1'b0;
    max_index   = '0;
  endfunction

  function automatic void enter_error();
    parse_state = xcp_pkg::MODE_ERROR;
    note(xcp_pkg::KIND_ERR, '0, 1'b0);
  endfunction

  function automatic void start_token(logic [7:0] ch);
    if (is_blank(ch)) begin
      parse_state = xcp_pkg::MODE_CLAUSE;
    end else if (ch == xcp_pkg::CH_LOWER_T || ch == xcp_pkg::CH_UPPER_T) begin
      clause_odd  = ~clause_odd;
      parse_state = xcp_pkg::MODE_CONST;
    end else if (ch == xcp_pkg::CH_LOWER_F || ch == xcp_pkg::CH_UPPER_F) begin
      parse_state = xcp_pkg::MODE_CONST;
    end else if (ch == xcp_pkg::CH_PLUS) begin
      parse_state = xcp_pkg::MODE_PLUS;
    end else if (is_digit(ch)) begin
      digits_val  = FB'(ch - xcp_pkg::CH_ZERO);
      parse_state = xcp_pkg::MODE_NUMBER;
    end else begin
      enter_error();
    end
  endfunction

  function automatic void between_clauses(logic [7:0] ch);
    if (ch == xcp_pkg::CH_NUL) begin
      note(xcp_pkg::KIND_DONE, '0, 1'b0);
      clear_text();
    end else if (ch == xcp_pkg::CH_LOWER_C || ch == xcp_pkg::CH_LOWER_P) begin
      parse_state = xcp_pkg::MODE_COMMENT;
    end else if (!is_blank(ch)) begin
      clause_odd = 1'b0;
      start_token(ch);
    end
  endfunction

  // Queue the results of one text byte, the final one flagged as last.
  function automatic void parse_byte(logic [7:0] ch);
    logic [31:0]   grown;
    xcp_pkg::res_t r;
    byte_results.delete();
    case (parse_state)
      xcp_pkg::MODE_BETWEEN: between_clauses(ch);
      xcp_pkg::MODE_COMMENT: begin
        if (ch == xcp_pkg::CH_NEWLINE) parse_state = xcp_pkg::MODE_BETWEEN;
        else if (ch == xcp_pkg::CH_NUL) between_clauses(ch);
      end
      xcp_pkg::MODE_CLAUSE: start_token(ch);
      xcp_pkg::MODE_PLUS: begin
        if (is_digit(ch)) start_token(ch);
        else enter_error();
      end
      xcp_pkg::MODE_CONST: begin
        if (is_blank(ch)) parse_state = xcp_pkg::MODE_CLAUSE;
        else enter_error();
      end
      xcp_pkg::MODE_NUMBER: begin
        if (is_digit(ch)) begin
          grown = 32'(digits_val) * 32'd10 + 32'(ch - xcp_pkg::CH_ZERO);
          if (grown > INDEX_MAX) enter_error();
          else digits_val = grown[FB-1:0];
        end else if (digits_val == '0) begin
          note(xcp_pkg::KIND_END, '0, clause_odd);
          clause_odd  = 1'b0;
          parse_state = xcp_pkg::MODE_BETWEEN;
          between_clauses(ch);
        end else begin
          if (digits_val > max_index) max_index = digits_val;
          note(xcp_pkg::KIND_VAR, digits_val, 1'b0);
          digits_val  = '0;
          parse_state = xcp_pkg::MODE_CLAUSE;
          start_token(ch);
        end
      end
      default: enter_error();
    endcase
    foreach (byte_results[i]) begin
      r      = byte_results[i];
      r.last = (i == byte_results.size() - 1);
      expected_results.push_back(r);
    end
  endfunction

  always @(posedge clk) begin : watch
    xcp_pkg::res_t got;
    xcp_pkg::res_t want;
    if (!rst_n) begin
      clear_text();
      expected_results.delete();
      fail_count    = 0;
      pending_count = 0;
      results_seen  = 0;
      clauses_seen  = 0;
      texts_seen    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind      = xcp_pkg::kind_t'(out_ch.kind);
        got.var_index = out_ch.var_index;
        got.odd_true  = out_ch.odd_true;
        got.max_var   = out_ch.max_var;
        got.last      = out_ch.last;
        results_seen++;
        if (got.kind == xcp_pkg::KIND_END) clauses_seen++;
        if (got.kind == xcp_pkg::KIND_DONE) texts_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: expected no result, got %s", $time, show(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: expected %s, got %s", $time, show(want), show(got));
          end
        end
      end
      // A byte accepted now cannot have its results out before the next edge.
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.text_byte);
      pending_count = expected_results.size();
    end
  end

endmodule

>>> bench/xor_clause_text_parser_tb.sv
`timescale 1ns / 1ps
// Top of the XOR clause text parser bench: clock, reset, text stimulus and
// verdict. Depends on xcp_pkg, xcp_if, the parser RTL and the scoreboard module.

module xor_clause_text_parser_tb;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          BYTE_TARGET = 1650;
  localparam int unsigned INDEX_MAX   = (1 << xcp_pkg::FIELD_BITS) - 1;

  logic  clk        = 1'b0;
  logic  rst_n      = 1'b0;
  logic  sink_ready = 1'b0;
  bit    steady     = 1'b0;
  int    sink_stall = 0;
  int    cycles     = 0;
  int    bytes_sent = 0;
  int    fail_count;
  int    pending_count;
  int    results_seen;
  int    clauses_seen;
  int    texts_seen;
  string error_case;

  xcp_in_if  in_ch ();
  xcp_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  xor_clause_text_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  xor_clause_text_parser_checker scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .results_seen  (results_seen),
    .clauses_seen  (clauses_seen),
    .texts_seen    (texts_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(negedge clk) begin
    if (sink_stall > 0) begin
      sink_ready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      sink_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_stall <= pick_gap();
    end
  end

  // Called at a falling edge; returns at the falling edge after the request.
  task automatic send(input logic [7:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.text_byte <= ch;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i]);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic put_blank();
    int pick;
    repeat ($urandom_range(1, 3)) begin
      pick = $urandom_range(7, 13);
      send(pick < 9 ? xcp_pkg::CH_SPACE : 8'(pick));
    end
  endtask

  function automatic int unsigned pick_index();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return $urandom_range(1, 20);
    if (roll < 85) return $urandom_range(1, 5000);
    if (roll < 95) return $urandom_range(1, INDEX_MAX);
    return INDEX_MAX;
  endfunction

  // A plus sign is forced when the previous number ended with no separator.
  task automatic put_index(input int unsigned v, input bit need_plus);
    if (need_plus || $urandom_range(0, 4) == 0) send(xcp_pkg::CH_PLUS);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send(xcp_pkg::CH_ZERO);
    send_text($sformatf("%0d", v));
  endtask

  // Leaves the parser inside the closing number; the caller ends it.
  task automatic put_clause();
    bit glued;
    glued = 1'b0;
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send($urandom_range(0, 1) ? xcp_pkg::CH_LOWER_T : xcp_pkg::CH_UPPER_T);
          put_blank();
          glued = 1'b0;
        end
        2: begin
          send($urandom_range(0, 1) ? xcp_pkg::CH_LOWER_F : xcp_pkg::CH_UPPER_F);
          put_blank();
          glued = 1'b0;
        end
        default: begin
          put_index(pick_index(), glued);
          glued = ($urandom_range(0, 3) == 0);
          if (!glued) put_blank();
        end
      endcase
    end
    put_index(0, glued);
  endtask

  task automatic put_comment(input bit ends_text);
    logic [7:0] ch;
    send($urandom_range(0, 1) ? xcp_pkg::CH_LOWER_C : xcp_pkg::CH_LOWER_P);
    repeat ($urandom_range(0, 12)) begin
      do ch = 8'($urandom_range(1, 255)); while (ch == xcp_pkg::CH_NEWLINE);
      send(ch);
    end
    send(ends_text ? xcp_pkg::CH_NUL : xcp_pkg::CH_NEWLINE);
  endtask

  task automatic put_text();
    int clauses;
    clauses = $urandom_range(1, 5);
    if ($urandom_range(0, 2) == 0) put_comment(1'b0);
    for (int i = 0; i < clauses; i++) begin
      put_clause();
      if (i == clauses - 1) begin
        case ($urandom_range(0, 3))
          0: send(xcp_pkg::CH_NUL);
          1: put_comment(1'b1);
          default: begin
            put_blank();
            send(xcp_pkg::CH_NUL);
          end
        endcase
      end else if ($urandom_range(0, 4) == 0) begin
        put_comment(1'b0);
      end else begin
        put_blank();
      end
    end
  endtask

  initial begin
    bit drained_once;
    drained_once    = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.text_byte = 8'h00;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Comment holding high bytes, then a clause with every token form.
    send(xcp_pkg::CH_LOWER_C);
    send(8'hFF);
    send(8'h80);
    send(xcp_pkg::CH_NEWLINE);
    send(xcp_pkg::CH_UPPER_T);
    send(xcp_pkg::CH_SPACE);
    send_text("+16777215");
    send(xcp_pkg::CH_TAB);
    send(xcp_pkg::CH_UPPER_F);
    send(8'd11);
    send_text("3f");
    send(8'd12);
    send(xcp_pkg::CH_ZERO);
    send(xcp_pkg::CH_CR);
    // Empty clause closed by the end of text, then a text ending in a comment.
    send(xcp_pkg::CH_ZERO);
    send(xcp_pkg::CH_NUL);
    send(xcp_pkg::CH_LOWER_P);
    send(xcp_pkg::CH_NUL);
    hold_until_drained();

    while (bytes_sent < BYTE_TARGET) begin
      steady = ($urandom_range(0, 6) == 0);
      put_text();
      if (!drained_once && bytes_sent > BYTE_TARGET / 2) begin
        hold_until_drained();
        drained_once = 1'b1;
      end
    end

    // Errors stick until reset, so exactly one kind closes the run.
    steady = 1'b0;
    put_blank();
    case ($urandom_range(0, 7))
      0: begin
        error_case = "number ended by a minus sign";
        send_text("5-");
      end
      1: begin
        error_case = "minus sign inside a clause";
        send_text("3 -");
      end
      2: begin
        error_case = "constant not followed by whitespace";
        send_text("t5");
      end
      3: begin
        error_case = "plus sign without a digit";
        send_text("+ ");
      end
      4: begin
        error_case = "index overflow";
        send_text($sformatf("%0d", longint'(INDEX_MAX) + 1));
      end
      5: begin
        error_case = "comment marker inside a clause";
        send_text("3 c");
      end
      6: begin
        error_case = "end of text inside a number";
        send_text("4");
        send(xcp_pkg::CH_NUL);
      end
      default: begin
        error_case = "bad byte between clauses";
        send(8'($urandom_range(128, 255)));
      end
    endcase
    repeat (12) send(8'($urandom_range(0, 255)));
    send(xcp_pkg::CH_NUL);

    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d text bytes; checked %0d results over %0d clauses and %0d texts.",
             bytes_sent, results_seen, clauses_seen, texts_seen);
    $display("Run closed on a sticky parse error: %s.", error_case);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/xcp_pkg.sv
rtl/xcp_if.sv
rtl/xcp_step.sv
rtl/xor_clause_text_parser.sv
rtl/xcp_checker.sv
bench/xor_clause_text_parser_checker.sv
bench/xor_clause_text_parser_tb.sv
